### rtl/core/iq_pulse_stream_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef IQ_PULSE_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define IQ_PULSE_STREAM_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define IPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define IPSD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define IPSD_ASSERT(lbl, prop, msg)

`define IPSD_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/core/ipsd_pkg.sv
// Package: shared types and constants of the IQ pulse stream deframer.
`timescale 1ns / 1ps

package ipsd_pkg;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 19;
  localparam int unsigned HDR_WORDS   = 6;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned GATES_CFG_W = 11;
  localparam int unsigned PULSE_CFG_W = 9;
  localparam int unsigned CHAN_W      = 2;
  localparam int unsigned CHAN_ID_W   = 3;

  typedef enum logic [1:0] {
    CFG_IQ_GATES          = 2'd0,
    CFG_PULSES_PER_BUFFER = 2'd1,
    CFG_CHANNEL_INDEX     = 2'd2,
    CFG_UNUSED            = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GATES_CFG_W-1:0] iq_gates;
    logic [PULSE_CFG_W-1:0] pulses_per_buffer;
    logic [CHAN_W-1:0]      channel_index;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sample_value;
    logic [IDX_W-1:0]         sample_index;
    logic                     buffer_done;
    logic                     buffer_queued;
    logic [31:0]              prt_id;
    logic [31:0]              pulse_count;
    logic [CHAN_W-1:0]        channel_index;
    logic                     channel_mismatch;
    logic                     block_end_out;
  } rec_t;

endpackage

### rtl/core/ipsd_ifs.sv
// Interfaces: input word channel and result channel.
`timescale 1ns / 1ps

interface ipsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stream_word;
  logic               free_buffer_ready;
  logic               block_end;

  modport source (output valid, output stream_word, output free_buffer_ready,
                  output block_end, input ready);
  modport sink (input valid, input stream_word, input free_buffer_ready,
                input block_end, output ready);
endinterface

interface ipsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic [18:0]        sample_index;
  logic               buffer_done;
  logic               buffer_queued;
  logic [31:0]        prt_id;
  logic [31:0]        pulse_count;
  logic [2:0]         channel_id;
  logic               channel_mismatch;
  logic               block_end_out;

  modport source (output valid, output sample_value, output sample_index,
                  output buffer_done, output buffer_queued, output prt_id,
                  output pulse_count, output channel_id, output channel_mismatch,
                  output block_end_out, input ready);
  modport sink (input valid, input sample_value, input sample_index,
                input buffer_done, input buffer_queued, input prt_id,
                input pulse_count, input channel_id, input channel_mismatch,
                input block_end_out, output ready);
endinterface

### rtl/core/ipsd_front.sv
// Front end: header capture, pulse and buffer framing, sample record build.
`timescale 1ns / 1ps
`include "iq_pulse_stream_deframer_core_defines.svh"

module ipsd_front #(
  parameter int unsigned MAX_GATES  = 1024,
  parameter int unsigned MAX_PULSES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipsd_pkg::cfg_t cfg_i,
  ipsd_in_if.sink       in_s,
  input  logic          q_ready_i,
  output logic          push_o,
  output ipsd_pkg::rec_t rec_o
);
  import ipsd_pkg::*;

  localparam int unsigned GATE_W  = $clog2(MAX_GATES + 1);
  localparam int unsigned PUL_W   = $clog2(MAX_PULSES + 1);
  localparam int unsigned CGW     = (GATE_W > GATES_CFG_W) ? GATE_W : GATES_CFG_W;
  localparam int unsigned CPW     = (PUL_W > PULSE_CFG_W) ? PUL_W : PULSE_CFG_W;
  localparam int unsigned PH_W    = $clog2(2 * MAX_GATES + HDR_WORDS + 1);
  localparam int unsigned FILL_W  = $clog2(2 * MAX_GATES * MAX_PULSES + 1);
  localparam int unsigned EXT_W   = (FILL_W > IDX_W) ? FILL_W : IDX_W;

  logic [PH_W-1:0]   phase_q, phase_d, phase_inc;
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [WORD_W-1:0] chan_lo_q, chan_lo_d;
  logic [31:0]       prt_q, prt_d, pulse_q, pulse_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic              mism_q, mism_d;

  logic [CGW-1:0]    gates_ext;
  logic [CPW-1:0]    pulses_ext;
  logic [GATE_W-1:0] gates_eff;
  logic [PUL_W-1:0]  pulses_eff;
  logic [PH_W-1:0]   pulse_len;
  logic [FILL_W-1:0] buf_size;
  logic [31:0]       expected;
  logic [WORD_W-1:0] w;
  logic              accept, is_sample, done;
  logic [EXT_W-1:0]  idx_ext;

  assign w        = in_s.stream_word;
  assign in_s.ready = q_ready_i;
  assign accept   = in_s.valid && q_ready_i;

  always_comb begin
    gates_ext  = CGW'(cfg_i.iq_gates);
    pulses_ext = CPW'(cfg_i.pulses_per_buffer);
    if (gates_ext == '0) begin
      gates_ext = CGW'(1);
    end else if (gates_ext > CGW'(MAX_GATES)) begin
      gates_ext = CGW'(MAX_GATES);
    end
    if (pulses_ext == '0) begin
      pulses_ext = CPW'(1);
    end else if (pulses_ext > CPW'(MAX_PULSES)) begin
      pulses_ext = CPW'(MAX_PULSES);
    end
    gates_eff  = GATE_W'(gates_ext);
    pulses_eff = PUL_W'(pulses_ext);
  end

  assign pulse_len = PH_W'({gates_eff, 1'b0}) + PH_W'(HDR_WORDS);
  assign buf_size  = (FILL_W'(gates_eff) * FILL_W'(pulses_eff)) << 1;
  assign expected  = 32'({cfg_i.channel_index, 1'b1});

  assign is_sample = (phase_q >= PH_W'(HDR_WORDS));
  assign phase_inc = phase_q + PH_W'(1);
  assign fill_inc  = fill_q + FILL_W'(1);
  assign done      = is_sample && (fill_inc >= buf_size);

  always_comb begin
    phase_d   = phase_q;
    fill_d    = fill_q;
    chan_lo_d = chan_lo_q;
    prt_d     = prt_q;
    pulse_d   = pulse_q;
    chan_d    = chan_q;
    mism_d    = mism_q;
    if (accept) begin
      phase_d = phase_inc;
      unique case (phase_q)
        PH_W'(0): chan_lo_d = w;
        PH_W'(1): begin
          mism_d = ({w, chan_lo_q} != expected);
          chan_d = cfg_i.channel_index;
        end
        PH_W'(2): prt_d = {16'h0000, w};
        PH_W'(3): prt_d = {w, prt_q[15:0]};
        PH_W'(4): pulse_d = {16'h0000, w};
        PH_W'(5): pulse_d = {w, pulse_q[15:0]};
        default: begin
          fill_d = fill_inc;
          if (phase_inc >= pulse_len) begin
            phase_d = '0;
          end
          if (done) begin
            fill_d  = '0;
            phase_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      fill_q    <= '0;
      chan_lo_q <= '0;
      prt_q     <= '0;
      pulse_q   <= '0;
      chan_q    <= '0;
      mism_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      fill_q    <= fill_d;
      chan_lo_q <= chan_lo_d;
      prt_q     <= prt_d;
      pulse_q   <= pulse_d;
      chan_q    <= chan_d;
      mism_q    <= mism_d;
    end
  end

  assign idx_ext = EXT_W'(fill_q);
  assign push_o  = accept && is_sample;

  always_comb begin
    rec_o.sample_value     = in_s.stream_word;
    rec_o.sample_index     = idx_ext[IDX_W-1:0];
    rec_o.buffer_done      = done;
    rec_o.buffer_queued    = done && in_s.free_buffer_ready;
    rec_o.prt_id           = prt_q;
    rec_o.pulse_count      = pulse_q;
    rec_o.channel_index    = chan_q;
    rec_o.channel_mismatch = mism_q;
    rec_o.block_end_out    = in_s.block_end;
  end

  `IPSD_ASSERT(a_done_restarts, push_o && done |=> fill_q == '0 && phase_q == '0, "fill not restarted after buffer done")
  `IPSD_NEVER(a_header_push, push_o && (phase_q < PH_W'(HDR_WORDS)), "header word produced a result")
  `IPSD_ASSERT(a_fill_advance, push_o && !done |=> fill_q == $past(fill_q) + FILL_W'(1), "fill index did not advance")

endmodule

### rtl/core/ipsd_queue.sv
// Two-entry queue between the front end and the output stage.
`timescale 1ns / 1ps
`include "iq_pulse_stream_deframer_core_defines.svh"

module ipsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ipsd_pkg::rec_t wdata_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ipsd_pkg::rec_t rdata_o
);
  import ipsd_pkg::*;

  rec_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `IPSD_NEVER(a_overflow, push_i && (cnt_q == 2'd2), "push into full queue")
  `IPSD_NEVER(a_underflow, pop_i && (cnt_q == 2'd0), "pop from empty queue")
  `IPSD_ASSERT(a_count_ptrs, (cnt_q == 2'd1) == (wptr_q != rptr_q), "count disagrees with pointers")

endmodule

### rtl/core/ipsd_back.sv
// Output stage: result register and channel number formatting.
`timescale 1ns / 1ps

module ipsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ipsd_pkg::rec_t rec_i,
  output logic           pop_o,
  ipsd_out_if.source     out_m
);
  import ipsd_pkg::*;

  logic valid_q;
  rec_t rec_q;

  assign pop_o = q_valid_i && (!valid_q || out_m.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_m.ready) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
  end

  assign out_m.valid            = valid_q;
  assign out_m.sample_value     = rec_q.sample_value;
  assign out_m.sample_index     = rec_q.sample_index;
  assign out_m.buffer_done      = rec_q.buffer_done;
  assign out_m.buffer_queued    = rec_q.buffer_queued;
  assign out_m.prt_id           = rec_q.prt_id;
  assign out_m.pulse_count      = rec_q.pulse_count;
  assign out_m.channel_id       = CHAN_ID_W'(rec_q.channel_index) + CHAN_ID_W'(1);
  assign out_m.channel_mismatch = rec_q.channel_mismatch;
  assign out_m.block_end_out    = rec_q.block_end_out;

endmodule

### rtl/core/iq_pulse_stream_deframer_core.sv
// Top level: IQ pulse stream deframer core.
`timescale 1ns / 1ps
// Usage:
//   stream_i carries one 16-bit DMA word per transfer. Each pulse is six
//   header words (channel id, PRT id, pulse count, low half first) followed
//   by 2*iq_gates sample words. Header words give no result; each sample word
//   gives one transfer on result_o with its buffer index and header fields.
//   Configuration (iq_gates, pulses_per_buffer, channel_index) is written
//   through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only
//   while the core is idle; the core itself does not enforce this.
//   Throughput: one word per cycle while the queue has room. A sample is
//   written into the queue, then loaded into the output register. buffer_size
//   is iq_gates*pulses_per_buffer*2 of the clamped values, from one multiplier.
//   Reset: framing restarts at the first header word, header fields clear,
//   registers return to iq_gates=1, pulses_per_buffer=1, channel_index=0.
//   Stall: a stalled receiver holds the output register; the queue absorbs
//   two more samples, after which stream_i.ready drops until the queue has room again.
module iq_pulse_stream_deframer_core #(
  parameter int unsigned MAX_GATES  = 1024,
  parameter int unsigned MAX_PULSES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  ipsd_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [ipsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ipsd_in_if.sink                         stream_i,
  ipsd_out_if.source                      result_o
);
  import ipsd_pkg::*;

  cfg_t cfg_q;
  rec_t f_rec, q_rec;
  logic f_push, q_ready, q_valid, b_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.iq_gates          <= GATES_CFG_W'(1);
      cfg_q.pulses_per_buffer <= PULSE_CFG_W'(1);
      cfg_q.channel_index     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IQ_GATES:          cfg_q.iq_gates <= cfg_data_i[GATES_CFG_W-1:0];
        CFG_PULSES_PER_BUFFER: cfg_q.pulses_per_buffer <= cfg_data_i[PULSE_CFG_W-1:0];
        CFG_CHANNEL_INDEX:     cfg_q.channel_index <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  ipsd_front #(
    .MAX_GATES  (MAX_GATES),
    .MAX_PULSES (MAX_PULSES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_s      (stream_i),
    .q_ready_i (q_ready),
    .push_o    (f_push),
    .rec_o     (f_rec)
  );

  ipsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_rec),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (b_pop),
    .rdata_o (q_rec)
  );

  ipsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .rec_i     (q_rec),
    .pop_o     (b_pop),
    .out_m     (result_o)
  );

endmodule

### verif/iq_pulse_stream_deframer_core_test.sv
`timescale 1ns / 1ps
// Testbench for the IQ pulse stream deframer core: framed word stimulus, predicted sample checks.
module iq_pulse_stream_deframer_core_test;
  import ipsd_pkg::*;

  localparam int unsigned MAX_G        = 1024;
  localparam int unsigned MAX_P        = 256;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 870;
  localparam int unsigned CALM_FROM    = 750;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned REPORT_CAP   = 200;

  // three two-sample pulses: good channel, bad high half, bad low half
  localparam logic [WORD_W-1:0] DIRECTED_WORDS [24] = '{
    16'h0001, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h8000, 16'h7fff, 16'h8000,
    16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'hffff, 16'h0000,
    16'h0003, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'hffff
  };
  localparam logic [23:0] DIRECTED_READY = 24'h800085;
  localparam logic [23:0] DIRECTED_END   = 24'h108040;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     done;
    logic                     queued;
    logic [31:0]              prt;
    logic [31:0]              pulse;
    logic [CHAN_ID_W-1:0]     chan_id;
    logic                     mismatch;
    logic                     bend;
  } sample_rec_t;

  class deframer_scoreboard;
    logic [GATES_CFG_W-1:0] gates_reg;
    logic [PULSE_CFG_W-1:0] pulses_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic [11:0]            word_phase;
    logic [IDX_W-1:0]       fill_pos;
    logic [31:0]            chan_word;
    logic [31:0]            prt_word;
    logic [31:0]            pulse_word;
    logic                   mismatch;
    sample_rec_t            expected_q[$];
    int unsigned            errors;
    int unsigned            buffers_done;

    function new();
      gates_reg    = GATES_CFG_W'(1);
      pulses_reg   = PULSE_CFG_W'(1);
      chan_reg     = '0;
      word_phase   = '0;
      fill_pos     = '0;
      chan_word    = '0;
      prt_word     = '0;
      pulse_word   = '0;
      mismatch     = 1'b0;
      errors       = 0;
      buffers_done = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IQ_GATES: begin
          gates_reg = data[GATES_CFG_W-1:0];
        end
        CFG_PULSES_PER_BUFFER: begin
          pulses_reg = data[PULSE_CFG_W-1:0];
        end
        CFG_CHANNEL_INDEX: begin
          chan_reg = data[CHAN_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void note_word(logic [WORD_W-1:0] w, logic fr, logic be);
      int unsigned gates, pulses, pulse_len, buf_len, nxt_phase, nxt_fill;
      logic [31:0] want_chan, id_sum;
      sample_rec_t rec;
      gates = (gates_reg == 0) ? 1 : (gates_reg > MAX_G) ? MAX_G : gates_reg;
      pulses = (pulses_reg == 0) ? 1 : (pulses_reg > MAX_P) ? MAX_P : pulses_reg;
      pulse_len = 2 * gates + HDR_WORDS;
      buf_len = 2 * gates * pulses;
      want_chan = 2 * chan_reg + 1;
      case (word_phase)
        0: chan_word = {16'h0000, w};
        1: begin
          chan_word = {w, chan_word[15:0]};
          mismatch = (chan_word != want_chan);
          chan_word = want_chan;
        end
        2: prt_word = {16'h0000, w};
        3: prt_word = {w, prt_word[15:0]};
        4: pulse_word = {16'h0000, w};
        5: pulse_word = {w, pulse_word[15:0]};
        default: ;
      endcase
      if (word_phase < HDR_WORDS) begin
        word_phase++;
        return;
      end
      rec.value  = w;
      rec.index  = fill_pos;
      rec.done   = 1'b0;
      rec.queued = 1'b0;
      nxt_fill = fill_pos + 1;
      nxt_phase = word_phase + 1;
      if (nxt_phase >= pulse_len) nxt_phase = 0;
      if (nxt_fill >= buf_len) begin
        rec.done   = 1'b1;
        rec.queued = fr;
        nxt_fill   = 0;
        nxt_phase  = 0;
        buffers_done++;
      end
      word_phase = nxt_phase[11:0];
      fill_pos = nxt_fill[IDX_W-1:0];
      id_sum = chan_word / 2 + 1;
      rec.prt      = prt_word;
      rec.pulse    = pulse_word;
      rec.chan_id  = id_sum[CHAN_ID_W-1:0];
      rec.mismatch = mismatch;
      rec.bend     = be;
      expected_q.insert(expected_q.size(), rec);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(sample_rec_t got);
      sample_rec_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: sample result expected none actual value %0h index %0h",
                   $time, got.value, got.index);
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("sample_value", 32'(want.value), 32'(got.value));
      compare_field("sample_index", 32'(want.index), 32'(got.index));
      compare_field("buffer_done", 32'(want.done), 32'(got.done));
      compare_field("buffer_queued", 32'(want.queued), 32'(got.queued));
      compare_field("prt_id", want.prt, got.prt);
      compare_field("pulse_count", want.pulse, got.pulse);
      compare_field("channel_id", 32'(want.chan_id), 32'(got.chan_id));
      compare_field("channel_mismatch", 32'(want.mismatch), 32'(got.mismatch));
      compare_field("block_end_out", 32'(want.bend), 32'(got.bend));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    calm;
  int unsigned           cycles;
  int unsigned           random_count;
  deframer_scoreboard    sb;

  ipsd_in_if  stream_if ();
  ipsd_out_if result_if ();

  iq_pulse_stream_deframer_core #(
    .MAX_GATES  (MAX_G),
    .MAX_PULSES (MAX_P)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stream_i   (stream_if),
    .result_o   (result_if)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_result(sample_rec_t'{value: result_if.sample_value,
                                    index: result_if.sample_index,
                                    done: result_if.buffer_done,
                                    queued: result_if.buffer_queued,
                                    prt: result_if.prt_id, pulse: result_if.pulse_count,
                                    chan_id: result_if.channel_id,
                                    mismatch: result_if.channel_mismatch,
                                    bend: result_if.block_end_out});
  end

  // receiver: stall in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] pick [4] = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000};
    if ($urandom_range(0, 7) == 0) return pick[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  // follow the predicted framing so most headers are well formed
  function automatic logic [WORD_W-1:0] next_word();
    logic [WORD_W-1:0] good;
    if (sb.word_phase > 1 || $urandom_range(0, 9) == 0) return random_word();
    good = (sb.word_phase == 0) ? 16'(2 * sb.chan_reg + 1) : 16'h0000;
    return good;
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] w, input logic fr, input logic be);
    if (!calm && $urandom_range(0, 5) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    stream_if.valid             <= 1'b1;
    stream_if.stream_word       <= w;
    stream_if.free_buffer_ready <= fr;
    stream_if.block_end         <= be;
    do @(posedge clk_i); while (!stream_if.ready);
    sb.note_word(w, fr, be);
  endtask

  task automatic push_random();
    push_word(next_word(), 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
  endtask

  // hold the sender until every transfer is out and the pipeline is empty
  task automatic quiesce();
    stream_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [GATES_CFG_W-1:0] g,
                              input logic [PULSE_CFG_W-1:0] p,
                              input logic [CHAN_W-1:0] c);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IQ_GATES;
    cfg_data_i <= CFG_DATA_W'(g);
    @(posedge clk_i);
    sb.write_reg(CFG_IQ_GATES, CFG_DATA_W'(g));
    cfg_idx_i  <= CFG_PULSES_PER_BUFFER;
    cfg_data_i <= CFG_DATA_W'(p);
    @(posedge clk_i);
    sb.write_reg(CFG_PULSES_PER_BUFFER, CFG_DATA_W'(p));
    cfg_idx_i  <= CFG_CHANNEL_INDEX;
    cfg_data_i <= CFG_DATA_W'(c);
    @(posedge clk_i);
    sb.write_reg(CFG_CHANNEL_INDEX, CFG_DATA_W'(c));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned n, pause_at, sel;
    logic [GATES_CFG_W-1:0] g;
    logic [PULSE_CFG_W-1:0] p;
    sel = $urandom_range(0, 19);
    if (sel == 0) g = '0;
    else if (sel < 4) g = GATES_CFG_W'($urandom_range(5, 16));
    else g = GATES_CFG_W'($urandom_range(1, 4));
    p = ($urandom_range(0, 9) == 0) ? '0 : PULSE_CFG_W'($urandom_range(1, 4));
    apply_config(g, p, CHAN_W'($urandom_range(0, 3)));
    n = $urandom_range(20, 100);
    pause_at = $urandom_range(0, 3 * n);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) quiesce();
      calm = (random_count >= CALM_FROM);
      push_random();
      random_count++;
    end
  endtask

  initial begin
    int unsigned start;
    clk_i                       = 1'b0;
    rst_ni                      = 1'b0;
    cfg_we_i                    = 1'b0;
    cfg_idx_i                   = CFG_IQ_GATES;
    cfg_data_i                  = '0;
    stream_if.valid             = 1'b0;
    stream_if.stream_word       = '0;
    stream_if.free_buffer_ready = 1'b0;
    stream_if.block_end         = 1'b0;
    result_if.ready             = 1'b0;
    calm                        = 1'b0;
    cycles                      = 0;
    random_count                = 0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 24; i++)
      push_word(DIRECTED_WORDS[i], DIRECTED_READY[i], DIRECTED_END[i]);

    // gate count above range: fill to index 510 under the clamped pulse length
    apply_config(11'd2047, 9'd0, 2'd3);
    while (sb.fill_pos != 510) push_random();
    // shrink mid-pulse: pulse count above range must finish at 512 samples
    apply_config(11'd1, 9'd511, 2'd0);
    start = sb.buffers_done;
    while (sb.buffers_done == start) push_random();
    apply_config(11'd1024, 9'd256, 2'd1);
    repeat (30) push_random();

    while (random_count < RANDOM_ITEMS) random_phase();

    stream_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
